// File: src/swm_pkg.sv
// Shared constants, types and helpers for the sliding window maximum block.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_W       = 7;
  localparam int PTR_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W       = CNT_W + 1;

  // one queue slot: candidate value and the position it arrived at
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [CNT_W-1:0]              pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result handed to the output stage
  typedef struct packed {
    logic                          load;
    logic signed [SAMPLE_BITS-1:0] value;
  } out_load_t;

  // circular slot index: base plus offset, offset never above WINDOW_MAX
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(WINDOW_MAX)) begin
      sum = sum - SUM_W'(WINDOW_MAX);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: src/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/swm_out_stage.sv
// Output register: holds one result item until the consumer takes it.
`timescale 1ns / 1ps

module swm_out_stage import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  out_load_t                     ld,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_max
);

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] data_r;

  // free when empty or when the held item leaves this cycle
  assign ready          = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_window_max = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld.load && ready) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load && ready) begin
      data_r <= ld.value;
    end
  end

endmodule

// File: src/sliding_window_maximum.sv
// Sliding window maximum filter: top level with queue control and configuration.
`timescale 1ns / 1ps

// Running maximum over the last window_len signed samples. Candidates sit in a
// circular queue in one RAM (value and arrival position per slot), values
// strictly decreasing from front to back. Per item: the sample is accepted and
// the front slot read, front entries that have aged out of the window are
// dropped one by one, then back entries not larger than the new sample are
// dropped one by one, and then the sample is written in and the result goes
// to the output register. Each sample is popped at most once. The queue RAM
// has a single read port, so entries are examined one slot per cycle, and no
// new sample is taken until the current one is through. A result waiting on
// a stalled output holds the block until the output register frees. A result
// is produced once window_len samples have been seen since the last seq_start;
// a window_len of 0 produces nothing, and values above 64 act as 64. The window
// register is written through cfg_valid/cfg_ready while the block is idle.
module sliding_window_maximum import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_seq_start,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_max,
  // window length register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_window_len
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for an item, front slot being read
    S_FCHK = 4'b0010,  // dropping aged entries off the front
    S_BCHK = 4'b0100,  // dropping smaller-or-equal entries off the back
    S_WAIT = 4'b1000   // result held until the output register frees
  } state_t;

  state_t                        state_r, state_nxt;
  logic [PTR_W-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [CNT_W-1:0]              seen_r, seen_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              cur_pos_r, cur_pos_nxt;
  logic [CFG_W-1:0]              win_r;
  logic signed [SAMPLE_BITS-1:0] samp_r, samp_nxt;
  logic signed [SAMPLE_BITS-1:0] front_r, front_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;

  logic [CNT_W-1:0]              w_eff;
  logic [CNT_W-1:0]              age;
  logic [CNT_W-1:0]              seen_inc;

  // queue RAM access
  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  logic [PTR_W-1:0]              ram_raddr;
  entry_t                        wr_entry;
  entry_t                        rd_entry;
  logic [ENTRY_W-1:0]            ram_rdata;

  out_load_t                     oload;
  logic                          out_rdy;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // clamp the window to the queue size
  assign w_eff = (32'(win_r) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_r);

  assign rd_entry = entry_t'(ram_rdata);
  assign age      = cur_pos_r - rd_entry.pos;   // modulo the position counter
  assign seen_inc = (seen_r < w_eff) ? seen_r + CNT_W'(1) : seen_r;

  assign wr_entry.val = samp_r;
  assign wr_entry.pos = cur_pos_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    seen_nxt    = seen_r;
    pos_nxt     = pos_r;
    cur_pos_nxt = cur_pos_r;
    samp_nxt    = samp_r;
    front_nxt   = front_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = slot_add(head_r, fill_r);
    ram_raddr   = head_r;
    oload.load  = 1'b0;
    oload.value = res_r;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = head_r;
        if (in_valid) begin
          if (in_seq_start) begin
            head_nxt = '0;
            fill_nxt = '0;
            seen_nxt = '0;
          end
          if (w_eff != '0) begin
            samp_nxt    = in_sample;
            cur_pos_nxt = pos_r;
            pos_nxt     = pos_r + CNT_W'(1);
            state_nxt   = S_FCHK;
          end
        end
      end

      S_FCHK: begin
        if (fill_r != '0 && age >= w_eff) begin
          head_nxt  = slot_add(head_r, CNT_W'(1));
          fill_nxt  = fill_r - CNT_W'(1);
          ram_raddr = head_nxt;
        end else begin
          // front survives: remember it for the result, fetch the back
          front_nxt = rd_entry.val;
          ram_raddr = (fill_r != '0) ? slot_add(head_r, fill_r - CNT_W'(1)) : head_r;
          state_nxt = S_BCHK;
        end
      end

      S_BCHK: begin
        if (fill_r != '0 && rd_entry.val <= samp_r) begin
          fill_nxt  = fill_r - CNT_W'(1);
          ram_raddr = (fill_r >= CNT_W'(2)) ? slot_add(head_r, fill_r - CNT_W'(2))
                                            : head_r;
        end else begin
          if (32'(fill_r) < WINDOW_MAX) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
          seen_nxt = seen_inc;
          if (seen_inc >= w_eff) begin
            // an empty queue means the new sample is the front
            res_nxt     = (fill_r == '0) ? samp_r : front_r;
            oload.value = res_nxt;
            if (out_rdy) begin
              oload.load = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt  = S_WAIT;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_WAIT: begin
        if (out_rdy) begin
          oload.load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      seen_r  <= '0;
      pos_r   <= '0;
      win_r   <= CFG_W'(1);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= pos_nxt;
      if (cfg_valid && cfg_ready) begin
        win_r <= cfg_window_len;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_pos_r <= cur_pos_nxt;
    samp_r    <= samp_nxt;
    front_r   <= front_nxt;
    res_r     <= res_nxt;
  end

  swm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_MAX)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swm_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld             (oload),
    .ready          (out_rdy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= WINDOW_MAX)
    else $error("queue fill above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < WINDOW_MAX)
    else $error("queue head out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && w_eff != '0 |=> in_stall)
    else $error("item accepted with nonzero window but block not busy");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_BCHK || $past(state_r) == S_WAIT))
    else $error("result appeared outside the insert or wait step");

  a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> fill_r < w_eff)
    else $error("insert into a queue already holding a full window");
`endif

endmodule
